>>> rtl/strmq_pkg.sv
// Shared types, constants and helpers of the sparse-table range-minimum engine.
// Used by every file under rtl except strmq_ram; depends on nothing.
`timescale 1ns / 1ps

package strmq_pkg;

  localparam int unsigned DefMaxElements = 1024;
  localparam int unsigned DefLevels      = 11;

  localparam int unsigned PosW   = 10;
  localparam int unsigned KeyW   = 32;
  localparam int unsigned TagW   = 16;
  localparam int unsigned EntryW = KeyW + TagW;
  localparam int unsigned LenW   = PosW + 1;
  localparam int unsigned KW     = 4;

  localparam logic [KeyW-1:0] KeyBias = 32'h8000_0000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_B_CHK,
    ST_B_RDA,
    ST_B_RDB,
    ST_B_WR,
    ST_Q_EVAL,
    ST_Q_RDA,
    ST_Q_RDB,
    ST_Q_CAP,
    ST_Q_OUT
  } ctrl_state_e;

  typedef enum logic [1:0] {
    RD_BLD_A,
    RD_BLD_B,
    RD_QRY_A,
    RD_QRY_B
  } rd_sel_e;

  typedef struct packed {
    logic    load_wr;
    logic    qry_cap;
    logic    bld_init;
    logic    lvl_next;
    logic    hold_cap;
    logic    best_cap;
    logic    bld_wr;
    logic    bld_done;
    logic    qry_eval;
    logic    out_load;
    rd_sel_e rd_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic is_query;
    logic pos_ok;
    logic last;
    logic entry_ok;
    logic lvl_last;
    logic qry_err;
    logic out_free;
  } dp_sts_t;

  // entries hold the key with its sign bit flipped, so an unsigned compare is the pair order
  function automatic logic [EntryW-1:0] pair_min(input logic [EntryW-1:0] a,
                                                 input logic [EntryW-1:0] b);
    return (a < b) ? a : b;
  endfunction

endpackage

>>> rtl/strmq_if.sv
// Request and response channel interfaces of the range-minimum engine.
// Depends on strmq_pkg for field widths.
`timescale 1ns / 1ps

interface strmq_req_if;
  logic                              valid;
  logic                              ready;
  logic                              func;
  logic [strmq_pkg::PosW-1:0]        position;
  logic signed [strmq_pkg::KeyW-1:0] elem_key;
  logic [strmq_pkg::TagW-1:0]        elem_tag;
  logic                              last_element;
  logic [strmq_pkg::PosW-1:0]        range_left;
  logic [strmq_pkg::PosW-1:0]        range_right;

  modport source (output valid, func, position, elem_key, elem_tag, last_element,
                  range_left, range_right, input ready);
  modport sink   (input valid, func, position, elem_key, elem_tag, last_element,
                  range_left, range_right, output ready);
endinterface

interface strmq_rsp_if;
  logic                              valid;
  logic                              ready;
  logic signed [strmq_pkg::KeyW-1:0] min_key;
  logic [strmq_pkg::TagW-1:0]        min_tag;
  logic                              range_error;

  modport source (output valid, min_key, min_tag, range_error, input ready);
  modport sink   (input valid, min_key, min_tag, range_error, output ready);
endinterface

>>> rtl/strmq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module strmq_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/strmq_ctrl.sv
// Sequencer of the range-minimum engine: request intake, table build walk, query steps.
// Depends on strmq_pkg; drives strmq_dpath through command and status structs.
`timescale 1ns / 1ps

module strmq_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  strmq_pkg::dp_sts_t  sts_i,
  output strmq_pkg::dp_cmd_t  cmd_o
);

  strmq_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= strmq_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.rd_sel = strmq_pkg::RD_BLD_A;
    case (state_q)
      strmq_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (sts_i.is_query) begin
            cmd_o.qry_cap = 1'b1;
            state_d       = strmq_pkg::ST_Q_EVAL;
          end else if (sts_i.pos_ok) begin
            cmd_o.load_wr = 1'b1;
            if (sts_i.last) begin
              cmd_o.bld_init = 1'b1;
              state_d        = strmq_pkg::ST_B_CHK;
            end
          end
        end
      end
      strmq_pkg::ST_B_CHK: begin
        if (sts_i.entry_ok) begin
          state_d = strmq_pkg::ST_B_RDA;
        end else if (sts_i.lvl_last) begin
          cmd_o.bld_done = 1'b1;
          state_d        = strmq_pkg::ST_IDLE;
        end else begin
          cmd_o.lvl_next = 1'b1;
        end
      end
      strmq_pkg::ST_B_RDA: begin
        cmd_o.rd_sel = strmq_pkg::RD_BLD_A;
        state_d      = strmq_pkg::ST_B_RDB;
      end
      strmq_pkg::ST_B_RDB: begin
        cmd_o.rd_sel   = strmq_pkg::RD_BLD_B;
        cmd_o.hold_cap = 1'b1;
        state_d        = strmq_pkg::ST_B_WR;
      end
      strmq_pkg::ST_B_WR: begin
        cmd_o.bld_wr = 1'b1;
        state_d      = strmq_pkg::ST_B_CHK;
      end
      strmq_pkg::ST_Q_EVAL: begin
        cmd_o.qry_eval = 1'b1;
        state_d = sts_i.qry_err ? strmq_pkg::ST_Q_OUT : strmq_pkg::ST_Q_RDA;
      end
      strmq_pkg::ST_Q_RDA: begin
        cmd_o.rd_sel = strmq_pkg::RD_QRY_A;
        state_d      = strmq_pkg::ST_Q_RDB;
      end
      strmq_pkg::ST_Q_RDB: begin
        cmd_o.rd_sel   = strmq_pkg::RD_QRY_B;
        cmd_o.hold_cap = 1'b1;
        state_d        = strmq_pkg::ST_Q_CAP;
      end
      strmq_pkg::ST_Q_CAP: begin
        cmd_o.best_cap = 1'b1;
        state_d        = strmq_pkg::ST_Q_OUT;
      end
      strmq_pkg::ST_Q_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = strmq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = strmq_pkg::ST_IDLE;
      end
    endcase
  end

  a_out_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> sts_i.out_free)
    else $error("result loaded while output register still occupied");

  a_last_starts_build: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && !sts_i.is_query && sts_i.pos_ok && sts_i.last)
    |=> (state_q == strmq_pkg::ST_B_CHK))
    else $error("final load did not start the build walk");

endmodule

>>> rtl/strmq_dpath.sv
// Datapath of the range-minimum engine: counters, table addressing, pair compare, result register.
// Depends on strmq_pkg; the table itself sits in strmq_ram outside this module.
`timescale 1ns / 1ps

module strmq_dpath #(
  parameter int unsigned MAX_ELEMENTS = strmq_pkg::DefMaxElements,
  parameter int unsigned LEVELS       = strmq_pkg::DefLevels,
  localparam int unsigned ADDR_W      = $clog2(MAX_ELEMENTS * LEVELS),
  localparam int unsigned IDX_W       = $clog2(MAX_ELEMENTS),
  localparam int unsigned LVL_W       = $clog2(LEVELS),
  localparam int unsigned CNT_W       = $clog2(MAX_ELEMENTS + 1)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  strmq_pkg::dp_cmd_t                  cmd_i,
  output strmq_pkg::dp_sts_t                  sts_o,
  input  logic                                func_i,
  input  logic [strmq_pkg::PosW-1:0]          position_i,
  input  logic signed [strmq_pkg::KeyW-1:0]   elem_key_i,
  input  logic [strmq_pkg::TagW-1:0]          elem_tag_i,
  input  logic                                last_element_i,
  input  logic [strmq_pkg::PosW-1:0]          range_left_i,
  input  logic [strmq_pkg::PosW-1:0]          range_right_i,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic signed [strmq_pkg::KeyW-1:0]   min_key_o,
  output logic [strmq_pkg::TagW-1:0]          min_tag_o,
  output logic                                range_error_o,
  output logic                                we_o,
  output logic [ADDR_W-1:0]                   waddr_o,
  output logic [strmq_pkg::EntryW-1:0]        wdata_o,
  output logic [ADDR_W-1:0]                   raddr_o,
  input  logic [strmq_pkg::EntryW-1:0]        rdata_i
);

  logic [CNT_W-1:0]                 count_q, count_d;
  logic                             ready_q, ready_d;
  logic [IDX_W-1:0]                 idx_q, idx_d;
  logic [LVL_W-1:0]                 lvl_q, lvl_d;
  logic [ADDR_W-1:0]                base_q, base_d;
  logic [strmq_pkg::PosW-1:0]       left_q, right_q;
  logic [strmq_pkg::KW-1:0]         k_q, k_d;
  logic                             err_q, err_d;
  logic [strmq_pkg::EntryW-1:0]     hold_q, best_q;
  logic                             out_valid_q;
  logic signed [strmq_pkg::KeyW-1:0] min_key_q;
  logic [strmq_pkg::TagW-1:0]       min_tag_q;
  logic                             range_error_q;
  logic [strmq_pkg::LenW-1:0]       len;
  logic [31:0]                      half, span;
  logic                             out_free;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      ready_q     <= 1'b0;
      idx_q       <= '0;
      lvl_q       <= '0;
      base_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      ready_q     <= ready_d;
      idx_q       <= idx_d;
      lvl_q       <= lvl_d;
      base_q      <= base_d;
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.qry_cap) begin
      left_q  <= range_left_i;
      right_q <= range_right_i;
    end
    if (cmd_i.qry_eval) begin
      k_q   <= k_d;
      err_q <= err_d;
    end
    if (cmd_i.hold_cap) begin
      hold_q <= rdata_i;
    end
    if (cmd_i.best_cap) begin
      best_q <= strmq_pkg::pair_min(hold_q, rdata_i);
    end
    if (cmd_i.out_load) begin
      range_error_q <= err_q;
      min_key_q     <= err_q ? '0 : (best_q[strmq_pkg::EntryW-1 -: strmq_pkg::KeyW]
                                     ^ strmq_pkg::KeyBias);
      min_tag_q     <= err_q ? '0 : best_q[strmq_pkg::TagW-1:0];
    end
  end

  assign span = 32'd1 << lvl_q;
  assign half = 32'd1 << (32'(lvl_q) - 32'd1);

  always_comb begin
    count_d = count_q;
    ready_d = ready_q;
    idx_d   = idx_q;
    lvl_d   = lvl_q;
    base_d  = base_q;
    if (cmd_i.load_wr) begin
      ready_d = 1'b0;
      if (last_element_i) begin
        count_d = CNT_W'(32'(position_i) + 32'd1);
      end
    end
    if (cmd_i.bld_init) begin
      idx_d  = '0;
      lvl_d  = LVL_W'(1);
      base_d = '0;
    end
    if (cmd_i.lvl_next) begin
      idx_d  = '0;
      lvl_d  = lvl_q + LVL_W'(1);
      base_d = base_q + ADDR_W'(MAX_ELEMENTS);
    end
    if (cmd_i.bld_wr) begin
      idx_d = idx_q + IDX_W'(1);
    end
    if (cmd_i.bld_done) begin
      ready_d = 1'b1;
    end
  end

  // query check: k = floor(log2(length))
  always_comb begin
    len = strmq_pkg::LenW'(right_q) - strmq_pkg::LenW'(left_q) + strmq_pkg::LenW'(1);
    k_d = '0;
    for (int b = 0; b < strmq_pkg::LenW; b++) begin
      if (len[b]) begin
        k_d = strmq_pkg::KW'(b);
      end
    end
    err_d = !ready_q || (left_q > right_q) || (32'(right_q) >= 32'(count_q)) ||
            (32'(k_d) >= LEVELS);
  end

  always_comb begin
    case (cmd_i.rd_sel)
      strmq_pkg::RD_BLD_A: raddr_o = base_q + ADDR_W'(idx_q);
      strmq_pkg::RD_BLD_B: raddr_o = ADDR_W'(32'(base_q) + 32'(idx_q) + half);
      strmq_pkg::RD_QRY_A: raddr_o = ADDR_W'(32'(k_q) * MAX_ELEMENTS + 32'(left_q));
      strmq_pkg::RD_QRY_B: raddr_o = ADDR_W'(32'(k_q) * MAX_ELEMENTS + 32'(right_q)
                                             + 32'd1 - (32'd1 << k_q));
      default:             raddr_o = '0;
    endcase
  end

  always_comb begin
    we_o    = cmd_i.load_wr || cmd_i.bld_wr;
    waddr_o = ADDR_W'(position_i);
    wdata_o = {elem_key_i ^ strmq_pkg::KeyBias, elem_tag_i};
    if (cmd_i.bld_wr) begin
      waddr_o = ADDR_W'(32'(base_q) + MAX_ELEMENTS + 32'(idx_q));
      wdata_o = strmq_pkg::pair_min(hold_q, rdata_i);
    end
  end

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    sts_o          = '0;
    sts_o.is_query = func_i;
    sts_o.pos_ok   = 32'(position_i) < MAX_ELEMENTS;
    sts_o.last     = last_element_i;
    sts_o.entry_ok = (32'(idx_q) + span) <= 32'(count_q);
    sts_o.lvl_last = 32'(lvl_q) == (LEVELS - 1);
    sts_o.qry_err  = err_d;
    sts_o.out_free = out_free;
  end

  assign out_valid_o   = out_valid_q;
  assign min_key_o     = min_key_q;
  assign min_tag_o     = min_tag_q;
  assign range_error_o = range_error_q;

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && range_error_o) |-> (min_key_o == '0 && min_tag_o == '0))
    else $error("rejected query carries a non-zero pair");

  a_ready_from_build: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ready_q) |-> $past(cmd_i.bld_done))
    else $error("table marked ready outside the end of a build");

  a_single_writer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.bld_wr |-> !cmd_i.load_wr)
    else $error("build and load write the table in the same cycle");

endmodule

>>> rtl/sparse_table_range_min.sv
// Sparse-table range-minimum engine. A load request (func 0) writes one (key, tag) pair at its
// position; the load with last_element set fixes the element count and starts the build walk,
// which fills each level j from the one below with a check, two reads and a write per entry
// (count - 2^j + 1 entries on level j); no request is taken during the walk. A query (func 1)
// evaluates, makes two reads from the single-read-port table RAM, compares and loads the output;
// a rejected query skips the reads and compare. Either stays longer while the output register
// still holds an earlier response; once loaded there, the response waits so the next request
// is taken while it is held. Pairs order by signed key, then tag. Rejected queries (table not
// built, left above right, right at or past the count, length >= 2^LEVELS) return range_error
// with zero key and tag. Depends on strmq_pkg, strmq_if, strmq_ram, strmq_ctrl and strmq_dpath.
`timescale 1ns / 1ps

module sparse_table_range_min #(
  parameter int unsigned MAX_ELEMENTS = strmq_pkg::DefMaxElements,
  parameter int unsigned LEVELS       = strmq_pkg::DefLevels
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  strmq_req_if.sink    req_i,
  strmq_rsp_if.source  rsp_o
);

  localparam int unsigned Depth = MAX_ELEMENTS * LEVELS;
  localparam int unsigned AddrW = $clog2(Depth);

  strmq_pkg::dp_cmd_t           cmd;
  strmq_pkg::dp_sts_t           sts;
  logic                         in_ready;
  logic                         we;
  logic [AddrW-1:0]             waddr, raddr;
  logic [strmq_pkg::EntryW-1:0] wdata, rdata;

  strmq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  assign req_i.ready = in_ready;

  strmq_dpath #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .LEVELS       (LEVELS)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .func_i         (req_i.func),
    .position_i     (req_i.position),
    .elem_key_i     (req_i.elem_key),
    .elem_tag_i     (req_i.elem_tag),
    .last_element_i (req_i.last_element),
    .range_left_i   (req_i.range_left),
    .range_right_i  (req_i.range_right),
    .out_ready_i    (rsp_o.ready),
    .out_valid_o    (rsp_o.valid),
    .min_key_o      (rsp_o.min_key),
    .min_tag_o      (rsp_o.min_tag),
    .range_error_o  (rsp_o.range_error),
    .we_o           (we),
    .waddr_o        (waddr),
    .wdata_o        (wdata),
    .raddr_o        (raddr),
    .rdata_i        (rdata)
  );

  strmq_ram #(
    .WIDTH (strmq_pkg::EntryW),
    .DEPTH (Depth)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

endmodule
